@@ hw/rtl/ptmr_pkg.sv @@
// Package: shared types, register indices and slot mapping for the prescaled timer.
package ptmr_pkg;

  localparam int unsigned DEFAULT_COUNTER_BITS = 32;
  localparam int unsigned NUM_PLAIN            = 15;
  localparam int unsigned SLOT_BITS            = $clog2(NUM_PLAIN);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  localparam logic [4:0] IDX_CTRL1    = 5'd0;
  localparam logic [4:0] IDX_IRQ_EN   = 5'd3;
  localparam logic [4:0] IDX_STATUS   = 5'd4;
  localparam logic [4:0] IDX_EGEN     = 5'd5;
  localparam logic [4:0] IDX_CCENABLE = 5'd8;
  localparam logic [4:0] IDX_COUNT    = 5'd9;
  localparam logic [4:0] IDX_PRESC    = 5'd10;
  localparam logic [4:0] IDX_RELOAD   = 5'd11;
  localparam logic [4:0] IDX_CMP1     = 5'd12;
  localparam logic [4:0] NUM_REGS     = 5'd19;

  localparam logic [15:0] PRESC_MASK = 16'hFFFF;
  localparam logic [31:0] ENABLE_BIT = 32'h0000_0001;
  localparam logic [31:0] UPDATE_BIT = 32'h0000_0001;

  // Request to the register store.
  typedef struct packed {
    logic                 re;
    logic                 we;
    logic [SLOT_BITS-1:0] addr;
    logic [31:0]          wdata;
  } mem_req_t;

  // Register index to a place in the store; plain is low for special and out-of-range registers.
  function automatic logic [SLOT_BITS:0] plain_slot(input logic [4:0] idx);
    logic                 plain;
    logic [SLOT_BITS-1:0] slot;
    plain = 1'b1;
    slot  = '0;
    if (idx >= NUM_REGS || idx == IDX_STATUS || idx == IDX_COUNT ||
        idx == IDX_PRESC || idx == IDX_RELOAD) begin
      plain = 1'b0;
    end else if (idx < IDX_STATUS) begin
      slot = SLOT_BITS'(idx);
    end else if (idx <= IDX_CCENABLE) begin
      slot = SLOT_BITS'(idx - 5'd1);
    end else begin
      slot = SLOT_BITS'(idx - 5'd4);
    end
    return {plain, slot};
  endfunction

endpackage

@@ hw/rtl/ptmr_regmem.sv @@
// Register store: the plain registers in a synchronous memory with per-entry valid bits.
module ptmr_regmem
  import ptmr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mem_req_t    req_i,
  output logic [31:0] rdata_o
);

  logic [31:0]          mem [NUM_PLAIN];
  logic [NUM_PLAIN-1:0] valid_q;
  logic [31:0]          rdata_q;

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= valid_q[req_i.addr] ? mem[req_i.addr] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/prescaled_reload_timer_regs.sv @@
// Top level: register-mapped up-counting timer with prescaler and auto-reload.
//
// Each request is a timer tick, a register read or a register write; every
// request gives exactly one response, in the cycle after it is accepted. The
// block takes one request per cycle for as long as responses are taken:
// the plain registers sit in a memory that is written in the accept cycle
// and read through an output register, so a read straight after a write to
// the same register sees the new value without forwarding. The counters,
// reload, prescaler and status live in flip-flops next to the tick logic,
// together with copies of the enable and interrupt-enable bits, so a tick
// completes in its accept cycle. A single response register parts the two
// sides; while it is held, no new request is taken. After reset the
// registers read as zero at once: no clearing pass is needed.
module prescaled_reload_timer_regs
  import ptmr_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = DEFAULT_COUNTER_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [4:0]  reg_index_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic        update_irq_o
);

  // Counter and special registers.
  logic [COUNTER_BITS-1:0] count_q, count_d;
  logic [15:0]             pcount_q, pcount_d;
  logic [15:0]             presc_q, presc_d;
  logic [31:0]             reload_q, reload_d;
  logic [31:0]             status_q, status_d;
  logic                    en_q, en_d;
  logic                    irq_en_q, irq_en_d;

  // Response register.
  logic        out_valid_q, out_valid_d;
  logic [31:0] rd_q, rd_d;
  logic        irq_q, irq_d;
  logic        mem_sel_q, mem_sel_d;

  logic                    accept;
  logic [SLOT_BITS:0]      slot_info;
  logic                    is_plain;
  logic [COUNTER_BITS-1:0] count_inc;
  mem_req_t                mem_req;
  logic [31:0]             mem_rdata;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign slot_info  = plain_slot(reg_index_i);
  assign is_plain   = slot_info[SLOT_BITS];
  assign count_inc  = count_q + COUNTER_BITS'(1);

  // Plain registers go to the store; everything else is handled here.
  always_comb begin
    mem_req.re    = accept && cmd_e'(cmd_i) == CMD_READ && is_plain;
    mem_req.we    = accept && cmd_e'(cmd_i) == CMD_WRITE && is_plain;
    mem_req.addr  = slot_info[SLOT_BITS-1:0];
    mem_req.wdata = write_data_i;
  end

  ptmr_regmem u_regmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    count_d     = count_q;
    pcount_d    = pcount_q;
    presc_d     = presc_q;
    reload_d    = reload_q;
    status_d    = status_q;
    en_d        = en_q;
    irq_en_d    = irq_en_q;
    out_valid_d = out_valid_q;
    rd_d        = rd_q;
    irq_d       = irq_q;
    mem_sel_d   = mem_sel_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      out_valid_d = 1'b1;
      rd_d        = '0;
      irq_d       = 1'b0;
      mem_sel_d   = 1'b0;
      case (cmd_e'(cmd_i))
        CMD_TICK: begin
          // Advance the prescaler; on its terminal value step the counter.
          if (en_q) begin
            if (pcount_q < presc_q) begin
              pcount_d = pcount_q + 16'd1;
            end else begin
              pcount_d = '0;
              if (reload_q != '0 && 32'(count_inc) == reload_q) begin
                count_d = '0;
                if (irq_en_q) begin
                  status_d = status_q | UPDATE_BIT;
                  irq_d    = 1'b1;
                end
              end else begin
                count_d = count_inc;
              end
            end
          end
        end
        CMD_READ: begin
          mem_sel_d = is_plain;
          case (reg_index_i)
            IDX_STATUS: rd_d = status_q;
            IDX_COUNT:  rd_d = 32'(count_q);
            IDX_PRESC:  rd_d = 32'(presc_q);
            IDX_RELOAD: rd_d = reload_q;
            default:    rd_d = '0;
          endcase
        end
        CMD_WRITE: begin
          case (reg_index_i)
            IDX_STATUS: status_d = status_q & write_data_i;
            IDX_COUNT:  count_d  = write_data_i[COUNTER_BITS-1:0];
            IDX_PRESC:  presc_d  = write_data_i[15:0] & PRESC_MASK;
            IDX_RELOAD: reload_d = write_data_i;
            IDX_CTRL1:  en_d     = (write_data_i & ENABLE_BIT) != '0;
            IDX_IRQ_EN: irq_en_d = (write_data_i & UPDATE_BIT) != '0;
            IDX_EGEN: begin
              // Update generation: clear both counters.
              if ((write_data_i & UPDATE_BIT) != '0) begin
                count_d  = '0;
                pcount_d = '0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pcount_q    <= '0;
      presc_q     <= '0;
      reload_q    <= '0;
      status_q    <= '0;
      en_q        <= 1'b0;
      irq_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pcount_q    <= pcount_d;
      presc_q     <= presc_d;
      reload_q    <= reload_d;
      status_q    <= status_d;
      en_q        <= en_d;
      irq_en_q    <= irq_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Response payload: no reset needed.
  always_ff @(posedge clk_i) begin
    rd_q      <= rd_d;
    irq_q     <= irq_d;
    mem_sel_q <= mem_sel_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = mem_sel_q ? mem_rdata : rd_q;
  assign update_irq_o = irq_q;

endmodule

@@ hw/rtl/ptmr_checker.sv @@
// Checker: port-level assertions for the prescaled timer, with its bind.
module ptmr_checker
  import ptmr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  cmd_i,
  input logic [4:0]  reg_index_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] read_data_o,
  input logic        update_irq_o
);

  // Held response stalls the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken while response held");

  // Every accepted request shows a response next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("response missing after request");

  // Unknown registers read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_READ && reg_index_i >= NUM_REGS
    |=> read_data_o == '0)
    else $error("unknown register read non-zero");

  // An interrupt pulse comes only from a tick, never with read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && update_irq_o |-> read_data_o == '0)
    else $error("interrupt with read data");

  // Stalled response holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) &&
    $stable(update_irq_o))
    else $error("stalled response changed");

endmodule

bind prescaled_reload_timer_regs ptmr_checker u_ptmr_checker (.*);
